// ===== design/bcd_pkg.sv =====
// Shared types and constants for the button click and long press detector.
package bcd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int THR_W           = 16;
  localparam int CLICK_W         = 8;
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = 16;
  localparam int MULTI_MIN       = 2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2,
    EV_MULTI = 2'd3
  } event_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ACTIVE_LEVEL = 4'd0,
    REG_LONG_EN      = 4'd1,
    REG_REPEAT_EN    = 4'd2,
    REG_MULTI_EN     = 4'd3,
    REG_SHORT_TICKS  = 4'd4,
    REG_LONG_TICKS   = 4'd5,
    REG_REPEAT_TICKS = 4'd6,
    REG_GAP_TICKS    = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic             active_level;
    logic             long_press_enable;
    logic             autorepeat_enable;
    logic             multiclick_enable;
    logic [THR_W-1:0] short_press_ticks;
    logic [THR_W-1:0] long_press_ticks;
    logic [THR_W-1:0] repeat_ticks;
    logic [THR_W-1:0] click_gap_ticks;
  } cfg_t;

endpackage

// ===== design/bcd_if.sv =====
// Handshake interfaces for the tick input, event result and configuration channels.
interface bcd_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

interface bcd_out_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           event_res;
  modport source (output valid, output event_res, input ready);
  modport sink (input valid, input event_res, output ready);
endinterface

interface bcd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bcd_pkg::CFG_ADDR_W-1:0] addr;
  logic [bcd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== design/bcd_cfg.sv =====
// Configuration register file written through the configuration channel.
module bcd_cfg (
  input  logic                 clk,
  input  logic                 rst_n,
  bcd_cfg_if.sink              cfg_ch,
  output bcd_pkg::cfg_t        cfg
);

  bcd_pkg::cfg_t cfg_r;
  bcd_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        bcd_pkg::REG_ACTIVE_LEVEL: cfg_nxt.active_level      = cfg_ch.data[0];
        bcd_pkg::REG_LONG_EN:      cfg_nxt.long_press_enable = cfg_ch.data[0];
        bcd_pkg::REG_REPEAT_EN:    cfg_nxt.autorepeat_enable = cfg_ch.data[0];
        bcd_pkg::REG_MULTI_EN:     cfg_nxt.multiclick_enable = cfg_ch.data[0];
        bcd_pkg::REG_SHORT_TICKS:  cfg_nxt.short_press_ticks = cfg_ch.data;
        bcd_pkg::REG_LONG_TICKS:   cfg_nxt.long_press_ticks  = cfg_ch.data;
        bcd_pkg::REG_REPEAT_TICKS: cfg_nxt.repeat_ticks      = cfg_ch.data;
        bcd_pkg::REG_GAP_TICKS:    cfg_nxt.click_gap_ticks   = cfg_ch.data;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/bcd_core.sv =====
// Press, click and gap counters with the per-tick event decision.
module bcd_core #(
  parameter int COUNT_WIDTH = bcd_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  logic             pin_level,
  input  bcd_pkg::cfg_t    cfg,
  output bcd_pkg::event_t  event_res
);

  localparam int CMP_W = (COUNT_WIDTH > bcd_pkg::THR_W) ? COUNT_WIDTH : bcd_pkg::THR_W;

  logic [COUNT_WIDTH-1:0]      press_ticks_r, press_ticks_nxt;
  logic [COUNT_WIDTH-1:0]      gap_ticks_r, gap_ticks_nxt;
  logic [bcd_pkg::CLICK_W-1:0] click_count_r, click_count_nxt;
  logic                        press_reported_r, press_reported_nxt;

  logic [COUNT_WIDTH-1:0]      press_inc;
  logic [COUNT_WIDTH-1:0]      gap_inc;
  logic [bcd_pkg::CLICK_W-1:0] click_inc;
  logic [CMP_W-1:0]            press_ext;
  logic [CMP_W-1:0]            press_inc_ext;
  logic [CMP_W-1:0]            gap_inc_ext;
  logic [CMP_W-1:0]            setback_ext;
  logic [bcd_pkg::THR_W-1:0]   setback;
  logic                        pressed;
  logic                        long_on;

  assign pressed       = (pin_level == cfg.active_level);
  assign long_on       = cfg.long_press_enable && (cfg.long_press_ticks != '0);
  assign press_inc     = (press_ticks_r == '1) ? press_ticks_r : press_ticks_r + 1'b1;
  assign gap_inc       = (gap_ticks_r == '1) ? gap_ticks_r : gap_ticks_r + 1'b1;
  assign click_inc     = (click_count_r == '1) ? click_count_r : click_count_r + 1'b1;
  assign press_ext     = CMP_W'(press_ticks_r);
  assign press_inc_ext = CMP_W'(press_inc);
  assign gap_inc_ext   = CMP_W'(gap_inc);
  assign setback       = (cfg.repeat_ticks > cfg.long_press_ticks) ? '0
                         : cfg.long_press_ticks - cfg.repeat_ticks;
  assign setback_ext   = CMP_W'(setback);

  always_comb begin
    press_ticks_nxt    = press_ticks_r;
    gap_ticks_nxt      = gap_ticks_r;
    click_count_nxt    = click_count_r;
    press_reported_nxt = press_reported_r;
    event_res          = bcd_pkg::EV_NONE;
    if (pressed) begin
      press_ticks_nxt = press_inc;
      if (long_on && (press_inc_ext == CMP_W'(cfg.long_press_ticks))) begin
        if (cfg.autorepeat_enable) begin
          press_ticks_nxt = setback_ext[COUNT_WIDTH-1:0];
        end
        press_reported_nxt = 1'b1;
        event_res          = bcd_pkg::EV_LONG;
      end
    end else if ((press_ext >= CMP_W'(cfg.short_press_ticks)) && !press_reported_r) begin
      press_ticks_nxt    = '0;
      press_reported_nxt = 1'b1;
      click_count_nxt    = click_inc;
      gap_ticks_nxt      = '0;
      if (cfg.multiclick_enable) begin
        if (click_inc > bcd_pkg::CLICK_W'(bcd_pkg::MULTI_MIN)) begin
          event_res = bcd_pkg::EV_MULTI;
        end
      end else begin
        event_res = bcd_pkg::EV_SHORT;
      end
    end else begin
      press_ticks_nxt    = '0;
      press_reported_nxt = 1'b0;
      gap_ticks_nxt      = gap_inc;
      if (gap_inc_ext >= CMP_W'(cfg.click_gap_ticks)) begin
        click_count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r    <= '0;
      gap_ticks_r      <= '0;
      click_count_r    <= '0;
      press_reported_r <= 1'b0;
    end else if (tick) begin
      press_ticks_r    <= press_ticks_nxt;
      gap_ticks_r      <= gap_ticks_nxt;
      click_count_r    <= click_count_nxt;
      press_reported_r <= press_reported_nxt;
    end
  end

endmodule

// ===== design/bcd_out_stage.sv =====
// Result register that holds one event item until the consumer takes it.
module bcd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  bcd_pkg::event_t  event_in,
  output logic             can_load,
  bcd_out_if.source        out_ch
);

  logic            out_valid_r, out_valid_nxt;
  bcd_pkg::event_t event_r;

  assign can_load         = !out_valid_r || out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = event_r;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_r <= event_in;
    end
  end

endmodule

// ===== design/button_click_long_press_detector.sv =====
// Top level of the button click, long press and multi-click detector.
//
//   Channel   Direction  Carries
//   in_ch     sink       pin_level, one sample tick per item
//   out_ch    source     event_res, one event item per tick item
//   cfg_ch    sink       addr (register index), data (write value)
//
// Each tick item's event item appears in the result register in the cycle after
// the tick is taken, so one item per cycle is sustained while out_ch is ready.
// The result register alone sets the rate: a tick is taken whenever that
// register is empty or is being emptied in the same cycle.
// Reset clears all counters, the result register's valid flag and the configuration.
module button_click_long_press_detector #(
  parameter int COUNT_WIDTH = bcd_pkg::COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bcd_in_if.sink    in_ch,
  bcd_out_if.source out_ch,
  bcd_cfg_if.sink   cfg_ch
);

  bcd_pkg::cfg_t   cfg;
  bcd_pkg::event_t core_event;
  logic            can_load;
  logic            tick;

  assign in_ch.ready = can_load;
  assign tick        = in_ch.valid && can_load;

  bcd_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bcd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .pin_level (in_ch.pin_level),
    .cfg       (cfg),
    .event_res (core_event)
  );

  bcd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (tick),
    .event_in (core_event),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
